### hdl/lrq_pkg.sv
// shared constants and types of the look rotation quaternion unit
package lrq_pkg;

	localparam int VEC_BITS          = 30;
	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int FLD_W             = 32;
	localparam int PROD_W            = 2 * FLD_W;
	localparam int CRS_W             = PROD_W + 1;
	localparam int VEC_W             = VEC_BITS + 2;
	localparam int MAT_W             = VEC_BITS + 4;
	localparam int QIN_W             = MAT_W + 2;
	localparam int NRM_W             = VEC_BITS + 1;
	localparam int SUM_W             = 64;
	localparam int RT_STEPS          = SUM_W / 2;
	localparam int LEN_W             = SUM_W / 2;

	// valid bit and degenerate mark that travel with an item
	typedef struct packed {
		logic valid;
		logic flag;
	} lrq_ctl_t;

	// quaternion extraction branch
	typedef enum logic [1:0] {
		BR_W,
		BR_X,
		BR_Y,
		BR_Z
	} lrq_branch_t;

endpackage

### hdl/lrq_norm.sv
// pipelined vector normalization: range scaling, square root and restoring division
module lrq_norm import lrq_pkg::*; #(
	parameter int CNT  = 3,
	parameter int IN_W = FLD_W,
	parameter int K    = VEC_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  lrq_ctl_t               in_ctl,
	input  logic signed [IN_W-1:0] in_vec [CNT],
	output lrq_ctl_t               out_ctl,
	output logic signed [K+1:0]    out_vec [CNT]
);

	localparam int PW = $clog2(IN_W);
	localparam int DW = LEN_W + K + 1;
	localparam int QW = K + 1;

	lrq_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic [CNT-1:0] neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [IN_W-1:0] mag_s1 [CNT];
	logic [IN_W-1:0] mag_s2 [CNT];
	logic [PW-1:0] pos_s2;
	logic zero_s2;
	logic [NRM_W-1:0] m_s3 [CNT];
	logic [NRM_W-1:0] m_s4 [CNT];
	logic [NRM_W-1:0] m_s5 [CNT];
	logic [2*NRM_W-1:0] sq_s4 [CNT];
	logic [SUM_W-1:0] sum_s5;
	logic [DW-1:0] rem_s6 [CNT];
	logic [LEN_W-1:0] len_s6;

	logic [IN_W-1:0] all_or;
	logic [PW-1:0] msb_pos;
	logic [IN_W+NRM_W-1:0] ext_sh [CNT];
	logic [NRM_W-1:0] m_sh [CNT];
	logic [SUM_W-1:0] sum_sq;

	// root chain links
	lrq_ctl_t rt_ctl [RT_STEPS+1];
	logic [SUM_W-1:0] rt_x [RT_STEPS+1];
	logic [SUM_W-1:0] rt_res [RT_STEPS+1];
	logic [NRM_W-1:0] rt_m [RT_STEPS+1][CNT];
	logic [CNT-1:0] rt_neg [RT_STEPS+1];

	// divider chain links
	lrq_ctl_t dv_ctl [QW+1];
	logic [DW-1:0] dv_rem [QW+1][CNT];
	logic [QW-1:0] dv_q [QW+1][CNT];
	logic [LEN_W-1:0] dv_len [QW+1];
	logic [CNT-1:0] dv_neg [QW+1];

	always_comb begin
		all_or = '0;
		msb_pos = '0;
		for (int i = 0; i < CNT; i++) all_or = all_or | mag_s1[i];
		for (int b = 0; b < IN_W; b++) begin
			if (all_or[b]) msb_pos = PW'(b);
		end
	end

	// bring the largest magnitude into [2^30, 2^31)
	always_comb begin
		for (int i = 0; i < CNT; i++) begin
			ext_sh[i] = {{NRM_W{1'b0}}, mag_s2[i]};
			if (int'(pos_s2) >= NRM_W) begin
				ext_sh[i] = ext_sh[i] >> (int'(pos_s2) - (NRM_W - 1));
			end else begin
				ext_sh[i] = ext_sh[i] << ((NRM_W - 1) - int'(pos_s2));
			end
			m_sh[i] = ext_sh[i][NRM_W-1:0];
		end
	end

	always_comb begin
		sum_sq = '0;
		for (int i = 0; i < CNT; i++) sum_sq = sum_sq + SUM_W'(sq_s4[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			out_ctl <= '0;
		end else if (en) begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= '{valid: ctl_s2.valid, flag: ctl_s2.flag | zero_s2};
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= rt_ctl[RT_STEPS];
			out_ctl <= dv_ctl[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < CNT; i++) begin
				mag_s1[i] <= in_vec[i][IN_W-1] ? IN_W'(-in_vec[i]) : IN_W'(in_vec[i]);
				mag_s2[i] <= mag_s1[i];
				m_s3[i] <= m_sh[i];
				sq_s4[i] <= m_s3[i] * m_s3[i];
				m_s4[i] <= m_s3[i];
				m_s5[i] <= m_s4[i];
				rem_s6[i] <= (DW'(rt_m[RT_STEPS][i]) << K)
					+ DW'(rt_res[RT_STEPS][LEN_W-1:0] >> 1);
				out_vec[i] <= dv_neg[QW][i] ? -(K+2)'(dv_q[QW][i]) : (K+2)'(dv_q[QW][i]);
			end
			for (int i = 0; i < CNT; i++) neg_s1[i] <= in_vec[i][IN_W-1];
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			neg_s4 <= neg_s3;
			neg_s5 <= neg_s4;
			neg_s6 <= rt_neg[RT_STEPS];
			pos_s2 <= msb_pos;
			zero_s2 <= (all_or == '0);
			sum_s5 <= sum_sq;
			len_s6 <= rt_res[RT_STEPS][LEN_W-1:0];
		end
	end

	assign rt_ctl[0] = ctl_s5;
	assign rt_x[0] = sum_s5;
	assign rt_res[0] = '0;
	assign rt_m[0] = m_s5;
	assign rt_neg[0] = neg_s5;

	// square root, one result bit per stage
	for (genvar j = 0; j < RT_STEPS; j++) begin : g_root
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * j);
		lrq_ctl_t ctl_s;
		logic [SUM_W-1:0] x_s, res_s, trial;
		logic [NRM_W-1:0] m_s [CNT];
		logic [CNT-1:0] neg_s;

		assign trial = rt_res[j] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s <= '0;
			end else if (en) begin
				ctl_s <= rt_ctl[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rt_x[j] >= trial) begin
					x_s <= rt_x[j] - trial;
					res_s <= (rt_res[j] >> 1) + BIT;
				end else begin
					x_s <= rt_x[j];
					res_s <= rt_res[j] >> 1;
				end
				m_s <= rt_m[j];
				neg_s <= rt_neg[j];
			end
		end

		assign rt_ctl[j+1] = ctl_s;
		assign rt_x[j+1] = x_s;
		assign rt_res[j+1] = res_s;
		assign rt_m[j+1] = m_s;
		assign rt_neg[j+1] = neg_s;
	end

	assign dv_ctl[0] = ctl_s6;
	assign dv_rem[0] = rem_s6;
	assign dv_len[0] = len_s6;
	assign dv_neg[0] = neg_s6;
	for (genvar i = 0; i < CNT; i++) begin : g_q0
		assign dv_q[0][i] = '0;
	end

	// restoring division, quotient msb first
	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int B = K - j;
		lrq_ctl_t ctl_s;
		logic [DW-1:0] rem_s [CNT];
		logic [QW-1:0] q_s [CNT];
		logic [LEN_W-1:0] len_s;
		logic [CNT-1:0] neg_s;
		logic [DW-1:0] dsh;

		assign dsh = DW'(dv_len[j]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s <= '0;
			end else if (en) begin
				ctl_s <= dv_ctl[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < CNT; i++) begin
					if (dv_rem[j][i] >= dsh) begin
						rem_s[i] <= dv_rem[j][i] - dsh;
						q_s[i] <= dv_q[j][i] | (QW'(1) << B);
					end else begin
						rem_s[i] <= dv_rem[j][i];
						q_s[i] <= dv_q[j][i];
					end
				end
				len_s <= dv_len[j];
				neg_s <= dv_neg[j];
			end
		end

		assign dv_ctl[j+1] = ctl_s;
		assign dv_rem[j+1] = rem_s;
		assign dv_q[j+1] = q_s;
		assign dv_len[j+1] = len_s;
		assign dv_neg[j+1] = neg_s;
	end

endmodule

### hdl/look_rotation_quaternion_unit.sv
// look rotation quaternion unit: top level with cross products, basis and quaternion pipeline
//
// Takes a forward vector and an up hint (32-bit signed, any fixed point, only the direction
// counts) and returns the unit quaternion of the rotation whose rows are right, up and
// forward, in Q1.(OUT_FRAC_BITS) held in OUT_FRAC_BITS+2 bits. A zero forward, an up hint
// parallel to forward or zero, or a vanishing quaternion gives the identity with degenerate
// set. One request is taken every clock while no finished result is held; the datapath is a
// pipeline whose bulk lies in the two normalizers on its path, each a chain of 32
// square-root stages and a restoring divider of one quotient bit per stage. The whole
// pipeline holds while a finished result waits under rsp_stall; otherwise it keeps moving
// and takes a new request on the same cycle the previous result leaves.
module look_rotation_quaternion_unit import lrq_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic signed [FLD_W-1:0]       fwd_x,
	input  logic signed [FLD_W-1:0]       fwd_y,
	input  logic signed [FLD_W-1:0]       fwd_z,
	input  logic signed [FLD_W-1:0]       up_x,
	input  logic signed [FLD_W-1:0]       up_y,
	input  logic signed [FLD_W-1:0]       up_z,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic signed [OUT_FRAC_BITS+1:0] quat_w,
	output logic signed [OUT_FRAC_BITS+1:0] quat_x,
	output logic signed [OUT_FRAC_BITS+1:0] quat_y,
	output logic signed [OUT_FRAC_BITS+1:0] quat_z,
	output logic                          degenerate
);

	localparam int OW = OUT_FRAC_BITS + 2;
	localparam logic signed [OW-1:0] ONE_Q = OW'(1) << OUT_FRAC_BITS;
	localparam logic signed [QIN_W-1:0] ONE_V = QIN_W'(1) << VEC_BITS;
	localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (VEC_BITS - 1);

	// global advance: everything moves unless a result is held at the output
	logic en;
	assign en = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	// stage valid and degenerate bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic deg_s4, deg_s5, deg_s6, deg_s7, deg_s8, deg_s9;

	// request and cross product U x F
	logic signed [FLD_W-1:0] f_s1 [3];
	logic signed [FLD_W-1:0] u_s1 [3];
	logic signed [FLD_W-1:0] f_s2 [3];
	logic signed [FLD_W-1:0] f_s3 [3];
	logic signed [PROD_W-1:0] pa_s2 [3];
	logic signed [PROD_W-1:0] pb_s2 [3];
	logic signed [CRS_W-1:0] c_s3 [3];

	// normalized forward and right, Q2.30
	lrq_ctl_t nin_ctl, nf_ctl, nc_ctl;
	logic signed [VEC_W-1:0] fn [3];
	logic signed [VEC_W-1:0] rn [3];

	// up = forward x right
	logic signed [PROD_W-1:0] pa_s4 [3];
	logic signed [PROD_W-1:0] pb_s4 [3];
	logic signed [PROD_W-1:0] d_s5 [3];
	logic signed [PROD_W-1:0] rnd [3];
	logic [MAT_W-1:0] ur_s6 [3];
	logic [2:0] un_s6;
	logic signed [MAT_W-1:0] u_s7 [3];
	logic signed [VEC_W-1:0] f_s4 [3], f_s5 [3], f_s6 [3], f_s7 [3];
	logic signed [VEC_W-1:0] r_s4 [3], r_s5 [3], r_s6 [3], r_s7 [3];

	// matrix rows right, up, forward and the quaternion before scaling
	logic signed [MAT_W-1:0] mr_s8 [3];
	logic signed [MAT_W-1:0] mu_s8 [3];
	logic signed [MAT_W-1:0] mf_s8 [3];
	logic signed [QIN_W-1:0] tr_s8;
	lrq_branch_t br_s8;
	logic signed [QIN_W-1:0] tr;
	lrq_branch_t br;
	logic signed [QIN_W-1:0] q_nx [4];
	logic signed [QIN_W-1:0] q_s9 [4];

	// quaternion normalizer
	lrq_ctl_t qin_ctl, qn_ctl;
	logic signed [OW-1:0] qn [4];

	function automatic logic signed [MAT_W-1:0] rn_ext(input logic signed [VEC_W-1:0] v);
		rn_ext = MAT_W'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			deg_s4 <= 1'b0;
			deg_s5 <= 1'b0;
			deg_s6 <= 1'b0;
			deg_s7 <= 1'b0;
			deg_s8 <= 1'b0;
			deg_s9 <= 1'b0;
			rsp_valid <= 1'b0;
		end else if (en) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= nf_ctl.valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			deg_s4 <= nf_ctl.flag | nc_ctl.flag;
			deg_s5 <= deg_s4;
			deg_s6 <= deg_s5;
			deg_s7 <= deg_s6;
			deg_s8 <= deg_s7;
			deg_s9 <= deg_s8;
			rsp_valid <= qn_ctl.valid;
		end
	end

	// request register, cross product of up and forward
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1[0] <= fwd_x;
			f_s1[1] <= fwd_y;
			f_s1[2] <= fwd_z;
			u_s1[0] <= up_x;
			u_s1[1] <= up_y;
			u_s1[2] <= up_z;
			pa_s2[0] <= u_s1[1] * f_s1[2];
			pb_s2[0] <= u_s1[2] * f_s1[1];
			pa_s2[1] <= u_s1[2] * f_s1[0];
			pb_s2[1] <= u_s1[0] * f_s1[2];
			pa_s2[2] <= u_s1[0] * f_s1[1];
			pb_s2[2] <= u_s1[1] * f_s1[0];
			f_s2 <= f_s1;
			for (int i = 0; i < 3; i++) c_s3[i] <= CRS_W'(pa_s2[i]) - CRS_W'(pb_s2[i]);
			f_s3 <= f_s2;
		end
	end

	assign nin_ctl = '{valid: vld_s3, flag: 1'b0};

	lrq_norm #(
		.CNT  (3),
		.IN_W (FLD_W),
		.K    (VEC_BITS)
	) u_norm_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (nin_ctl),
		.in_vec  (f_s3),
		.out_ctl (nf_ctl),
		.out_vec (fn)
	);

	lrq_norm #(
		.CNT  (3),
		.IN_W (CRS_W),
		.K    (VEC_BITS)
	) u_norm_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (nin_ctl),
		.in_vec  (c_s3),
		.out_ctl (nc_ctl),
		.out_vec (rn)
	);

	// round half away from zero by folding the sign into one add
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rnd[i] = d_s5[i][PROD_W-1] ? (HALF_LSB - d_s5[i]) : (d_s5[i] + HALF_LSB);
		end
	end

	// branch pick: positive trace, then largest diagonal
	always_comb begin
		tr = QIN_W'(rn_ext(r_s7[0])) + QIN_W'(u_s7[1]) + QIN_W'(rn_ext(f_s7[2]));
		if (tr > 0) begin
			br = BR_W;
		end else if (MAT_W'(r_s7[0]) >= u_s7[1] && MAT_W'(r_s7[0]) >= MAT_W'(f_s7[2])) begin
			br = BR_X;
		end else if (u_s7[1] > MAT_W'(f_s7[2])) begin
			br = BR_Y;
		end else begin
			br = BR_Z;
		end
	end

	// unscaled quaternion w, x, y, z per branch
	always_comb begin
		case (br_s8)
			BR_W: begin
				q_nx[0] = tr_s8 + ONE_V;
				q_nx[1] = QIN_W'(mu_s8[2]) - QIN_W'(mf_s8[1]);
				q_nx[2] = QIN_W'(mf_s8[0]) - QIN_W'(mr_s8[2]);
				q_nx[3] = QIN_W'(mr_s8[1]) - QIN_W'(mu_s8[0]);
			end
			BR_X: begin
				q_nx[0] = QIN_W'(mu_s8[2]) - QIN_W'(mf_s8[1]);
				q_nx[1] = ONE_V + QIN_W'(mr_s8[0]) - QIN_W'(mu_s8[1]) - QIN_W'(mf_s8[2]);
				q_nx[2] = QIN_W'(mr_s8[1]) + QIN_W'(mu_s8[0]);
				q_nx[3] = QIN_W'(mr_s8[2]) + QIN_W'(mf_s8[0]);
			end
			BR_Y: begin
				q_nx[0] = QIN_W'(mf_s8[0]) - QIN_W'(mr_s8[2]);
				q_nx[1] = QIN_W'(mu_s8[0]) + QIN_W'(mr_s8[1]);
				q_nx[2] = ONE_V + QIN_W'(mu_s8[1]) - QIN_W'(mr_s8[0]) - QIN_W'(mf_s8[2]);
				q_nx[3] = QIN_W'(mf_s8[1]) + QIN_W'(mu_s8[2]);
			end
			BR_Z: begin
				q_nx[0] = QIN_W'(mr_s8[1]) - QIN_W'(mu_s8[0]);
				q_nx[1] = QIN_W'(mf_s8[0]) + QIN_W'(mr_s8[2]);
				q_nx[2] = QIN_W'(mf_s8[1]) + QIN_W'(mu_s8[2]);
				q_nx[3] = ONE_V + QIN_W'(mf_s8[2]) - QIN_W'(mr_s8[0]) - QIN_W'(mu_s8[1]);
			end
			default: begin
				for (int i = 0; i < 4; i++) q_nx[i] = '0;
			end
		endcase
	end

	// up vector, matrix and quaternion stages
	always_ff @(posedge clk) begin
		if (en) begin
			pa_s4[0] <= fn[1] * rn[2];
			pb_s4[0] <= fn[2] * rn[1];
			pa_s4[1] <= fn[2] * rn[0];
			pb_s4[1] <= fn[0] * rn[2];
			pa_s4[2] <= fn[0] * rn[1];
			pb_s4[2] <= fn[1] * rn[0];
			f_s4 <= fn;
			r_s4 <= rn;
			for (int i = 0; i < 3; i++) begin
				d_s5[i] <= pa_s4[i] - pb_s4[i];
				ur_s6[i] <= MAT_W'(rnd[i] >>> VEC_BITS);
				un_s6[i] <= d_s5[i][PROD_W-1];
				u_s7[i] <= un_s6[i] ? -$signed(ur_s6[i]) : $signed(ur_s6[i]);
				mr_s8[i] <= rn_ext(r_s7[i]);
				mu_s8[i] <= u_s7[i];
				mf_s8[i] <= rn_ext(f_s7[i]);
			end
			f_s5 <= f_s4;
			r_s5 <= r_s4;
			f_s6 <= f_s5;
			r_s6 <= r_s5;
			f_s7 <= f_s6;
			r_s7 <= r_s6;
			tr_s8 <= tr;
			br_s8 <= br;
			q_s9 <= q_nx;
		end
	end

	assign qin_ctl = '{valid: vld_s9, flag: deg_s9};

	lrq_norm #(
		.CNT  (4),
		.IN_W (QIN_W),
		.K    (OUT_FRAC_BITS)
	) u_norm_quat (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_ctl  (qin_ctl),
		.in_vec  (q_s9),
		.out_ctl (qn_ctl),
		.out_vec (qn)
	);

	// output register, identity on degenerate input
	always_ff @(posedge clk) begin
		if (en) begin
			if (qn_ctl.flag) begin
				quat_w <= ONE_Q;
				quat_x <= '0;
				quat_y <= '0;
				quat_z <= '0;
			end else begin
				quat_w <= qn[0];
				quat_x <= qn[1];
				quat_y <= qn[2];
				quat_z <= qn[3];
			end
			degenerate <= qn_ctl.flag;
		end
	end

	a_deg_identity: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && degenerate |->
			quat_w == ONE_Q && quat_x == '0 && quat_y == '0 && quat_z == '0)
		else $error("degenerate result is not the identity");

	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> quat_w <= ONE_Q && quat_w >= -ONE_Q && quat_x <= ONE_Q
			&& quat_x >= -ONE_Q && quat_y <= ONE_Q && quat_y >= -ONE_Q
			&& quat_z <= ONE_Q && quat_z >= -ONE_Q)
		else $error("quaternion component beyond one");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !degenerate |->
			quat_w != '0 || quat_x != '0 || quat_y != '0 || quat_z != '0)
		else $error("normalized quaternion is zero");

	a_norm_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		nf_ctl.valid == nc_ctl.valid)
		else $error("forward and right normalizers out of step");

endmodule

### tb/testbench.sv
// self-checking testbench of the look rotation quaternion unit
module testbench import lrq_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OFB     = OUT_FRAC_BITS_DEF;
	localparam int QW      = OFB + 2;
	localparam int LATENCY = OFB + 120;
	localparam int N_RAND  = 2000;

	// one request: forward and up hint
	typedef struct {
		logic signed [31:0] fx, fy, fz, ux, uy, uz;
	} look_req_t;

	// one expected rotation
	typedef struct {
		logic [QW-1:0] w, x, y, z;
		logic          degen;
	} quat_t;

	logic clk, arst_n;
	logic req_valid, req_stall, rsp_valid, rsp_stall;
	logic signed [31:0] fwd_x, fwd_y, fwd_z, up_x, up_y, up_z;
	logic signed [QW-1:0] quat_w, quat_x, quat_y, quat_z;
	logic degenerate;

	look_req_t pending_reqs[$];
	quat_t     expected_quats[$];
	int        errors = 0;
	int        n_sent = 0;
	int        n_checked = 0;
	int        n_degen = 0;
	bit        stim_done = 0;
	bit        hold_long = 0;

	look_rotation_quaternion_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.degenerate(degenerate)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// ---------------- predictor ----------------

	function automatic longint unsigned magn(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// magnitude rounded half away from zero, shifted right by the vector fraction
	function automatic longint round_shift(longint v);
		longint unsigned m;
		m = (magn(v) + (64'd1 << (VEC_BITS - 1))) >> VEC_BITS;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	// scale cnt components to unit length with k fraction bits; 0 when all zero
	function automatic bit unit_scale(input longint v[4], input int cnt, input int k,
			output longint o[4]);
		longint unsigned m[4];
		longint unsigned mx, sum, len, q;
		mx = 0;
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			o[i] = 0;
			m[i] = (i < cnt) ? magn(v[i]) : 0;
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx == 0)
			return 0;
		while (mx >= (64'd1 << 31)) begin
			for (int i = 0; i < 4; i++)
				m[i] >>= 1;
			mx >>= 1;
		end
		while (mx < (64'd1 << 30)) begin
			for (int i = 0; i < 4; i++)
				m[i] <<= 1;
			mx <<= 1;
		end
		for (int i = 0; i < cnt; i++)
			sum += m[i] * m[i];
		len = int_sqrt(sum);
		for (int i = 0; i < cnt; i++) begin
			q = ((m[i] << k) + (len >> 1)) / len;
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic quat_t look_rotation(look_req_t r);
		longint fv[4], uv[4], cv[4], f[4], rt[4], u[4], q[4], n[4];
		longint m00, m01, m02, m10, m11, m12, m20, m21, m22, tr;
		longint one;
		bit ok;
		quat_t res;
		one = 64'sd1 << VEC_BITS;
		fv = '{longint'(r.fx), longint'(r.fy), longint'(r.fz), 0};
		uv = '{longint'(r.ux), longint'(r.uy), longint'(r.uz), 0};
		// exact cross product of up hint and forward
		cv[0] = uv[1] * fv[2] - uv[2] * fv[1];
		cv[1] = uv[2] * fv[0] - uv[0] * fv[2];
		cv[2] = uv[0] * fv[1] - uv[1] * fv[0];
		cv[3] = 0;
		ok = unit_scale(fv, 3, VEC_BITS, f);
		if (ok)
			ok = unit_scale(cv, 3, VEC_BITS, rt);
		if (ok) begin
			u[0] = round_shift(f[1] * rt[2] - f[2] * rt[1]);
			u[1] = round_shift(f[2] * rt[0] - f[0] * rt[2]);
			u[2] = round_shift(f[0] * rt[1] - f[1] * rt[0]);
			m00 = rt[0]; m01 = rt[1]; m02 = rt[2];
			m10 = u[0];  m11 = u[1];  m12 = u[2];
			m20 = f[0];  m21 = f[1];  m22 = f[2];
			tr = m00 + m11 + m22;
			// four-branch extraction, scale removed by the final normalization
			if (tr > 0) begin
				q = '{tr + one, m12 - m21, m20 - m02, m01 - m10};
			end else if (m00 >= m11 && m00 >= m22) begin
				q = '{m12 - m21, one + m00 - m11 - m22, m01 + m10, m02 + m20};
			end else if (m11 > m22) begin
				q = '{m20 - m02, m10 + m01, one + m11 - m00 - m22, m21 + m12};
			end else begin
				q = '{m01 - m10, m20 + m02, m21 + m12, one + m22 - m00 - m11};
			end
			ok = unit_scale(q, 4, OFB, n);
		end
		if (!ok)
			n = '{64'sd1 << OFB, 0, 0, 0};
		res.w = n[0][QW-1:0];
		res.x = n[1][QW-1:0];
		res.y = n[2][QW-1:0];
		res.z = n[3][QW-1:0];
		res.degen = !ok;
		return res;
	endfunction

	// ---------------- stimulus ----------------

	function automatic logic signed [31:0] rnd_comp();
		case ($urandom_range(0, 7))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom_range(0, 4)) - 32'sd2;
			3: return 32'($urandom_range(0, 131072)) - 32'sd65536;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(logic signed [31:0] fx, fy, fz, ux, uy, uz);
		look_req_t r;
		r = '{fx, fy, fz, ux, uy, uz};
		pending_reqs.push_back(r);
	endtask

	initial begin
		logic signed [31:0] k;
		// directed: axes, extremes, zero forward, parallel and zero up, each branch
		add_req(0, 0, 32'sh10000, 0, 32'sh10000, 0);
		add_req(0, 0, -32'sh10000, 0, 32'sh10000, 0);
		add_req(32'sh10000, 0, 0, 0, 32'sh10000, 0);
		add_req(-32'sh10000, 0, 0, 0, 32'sh10000, 0);
		add_req(0, 32'sh10000, 0, 0, 0, 32'sh10000);
		add_req(0, -32'sh10000, 0, 32'sh10000, 0, 0);
		add_req(0, 0, 0, 0, 32'sh10000, 0);
		add_req(0, 0, 0, 0, 0, 0);
		add_req(0, 0, 32'sh10000, 0, 0, 32'sh30000);
		add_req(0, 0, 32'sh10000, 0, 0, 0);
		add_req(32'sh10000, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh20000, 32'sh20000);
		add_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 0, 32'sh7fffffff);
		add_req(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0, 0);
		add_req(32'sh80000000, 0, 0, 0, 32'sh80000000, 0);
		add_req(1, 0, 0, 0, 1, 0);
		add_req(-1, -1, 1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		add_req(32'hffffffff, 32'h7fffffff, 1, 32'haaaaaaaa, 32'h55555555, 32'hffffffff);
		add_req(0, 32'sh10000, 32'sh10000, 0, 32'sh10000, -32'sh10000);
		for (int i = 0; i < N_RAND; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					// parallel up hint, scaled by a small factor
					look_req_t r;
					k = 32'($urandom_range(0, 6)) - 32'sd3;
					r.fx = 32'($urandom_range(0, 65535)) - 32'sd32768;
					r.fy = 32'($urandom_range(0, 65535)) - 32'sd32768;
					r.fz = 32'($urandom_range(0, 65535)) - 32'sd32768;
					add_req(r.fx, r.fy, r.fz, r.fx * k, r.fy * k, r.fz * k);
				end
				1: add_req(0, 0, 0, rnd_comp(), rnd_comp(), rnd_comp());
				default: add_req(rnd_comp(), rnd_comp(), rnd_comp(),
					rnd_comp(), rnd_comp(), rnd_comp());
			endcase
		end
		stim_done = 1;
	end

	// ---------------- driver: bursts with gaps ----------------

	int burst_left = 0;
	int gap_left = 0;

	// stall seen at the rising edge, so acceptance is judged as the block saw it
	logic req_stall_q = 1'b0;
	always @(posedge clk)
		req_stall_q <= req_stall;

	initial begin
		req_valid = 0;
		{fwd_x, fwd_y, fwd_z, up_x, up_y, up_z} = '0;
		rsp_stall = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	always @(negedge clk) begin
		logic nxt_valid;
		nxt_valid = req_valid;
		if (arst_n) begin
			// a request accepted at the last rising edge is retired here
			if (req_valid && !req_stall_q) begin
				n_sent++;
				nxt_valid = 1'b0;
			end
			if (!(req_valid && req_stall_q)) begin
				if (gap_left > 0) begin
					gap_left--;
					nxt_valid = 1'b0;
				end else if (pending_reqs.size() > 0) begin
					look_req_t r;
					r = pending_reqs.pop_front();
					expected_quats.push_back(look_rotation(r));
					fwd_x <= r.fx; fwd_y <= r.fy; fwd_z <= r.fz;
					up_x <= r.ux;  up_y <= r.uy;  up_z <= r.uz;
					nxt_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
					end
				end
			end
			req_valid <= nxt_valid;
		end
	end

	// ---------------- receiver stall pattern ----------------

	int stall_mode = 0;
	int hold_count = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			// one long hold-off once the block has had time to fill
			if (!hold_long && n_sent >= 300) begin
				hold_long <= 1'b1;
				hold_count = 3 * LATENCY;
			end
			if (hold_count > 0) begin
				hold_count--;
				rsp_stall <= 1'b1;
			end else begin
				if ($urandom_range(0, 199) == 0)
					stall_mode = $urandom_range(0, 2);
				case (stall_mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					default: rsp_stall <= ($urandom_range(0, 1) == 0);
				endcase
			end
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_quats.size() == 0) begin
				$display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d degenerate=%0b",
					$time, quat_w, quat_x, quat_y, quat_z, degenerate);
				errors++;
			end else begin
				quat_t e;
				e = expected_quats.pop_front();
				if (quat_w !== e.w) begin
					$display("%0t: quat_w expected %h actual %h", $time, e.w, quat_w);
					errors++;
				end
				if (quat_x !== e.x) begin
					$display("%0t: quat_x expected %h actual %h", $time, e.x, quat_x);
					errors++;
				end
				if (quat_y !== e.y) begin
					$display("%0t: quat_y expected %h actual %h", $time, e.y, quat_y);
					errors++;
				end
				if (quat_z !== e.z) begin
					$display("%0t: quat_z expected %h actual %h", $time, e.z, quat_z);
					errors++;
				end
				if (degenerate !== e.degen) begin
					$display("%0t: degenerate expected %b actual %b",
						$time, e.degen, degenerate);
					errors++;
				end
				if (e.degen)
					n_degen++;
				n_checked++;
			end
		end
	end

	// ---------------- end of run ----------------

	initial begin
		wait (stim_done);
		wait (pending_reqs.size() == 0 && !req_valid && expected_quats.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		$display("checked %0d rotations, %0d of them degenerate, with bursty requests,",
			n_checked, n_degen);
		$display("random response stalls and one long hold-off that filled the pipeline");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("FAIL");
		$finish;
	end

endmodule

### look_rotation_quaternion_unit.f
hdl/lrq_pkg.sv
hdl/lrq_norm.sv
hdl/look_rotation_quaternion_unit.sv
tb/testbench.sv
